>>> sv/skt_pkg.sv
// skt_pkg: shared constants, codes and control types for the sorted key table
// no dependencies
`default_nettype none

package skt_pkg;

  localparam int unsigned DEPTH_DEF    = 32;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_ONE,
    PTR_FILL,
    PTR_FILL_M1,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,
    POS_FILL,
    POS_PTR
  } pos_op_e;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC
  } fill_op_e;

  typedef struct packed {
    logic                load;
    logic                rd_en;
    rd_sel_e             rd_sel;
    ptr_op_e             ptr_op;
    pos_op_e             pos_op;
    logic                we;
    logic                wr_new;
    fill_op_e            fill_op;
    logic                capture;
    logic                set_status;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              key_ge;
    logic              key_le;
    logic              key_eq;
    logic              ptr_eq_fill;
    logic              ptr_eq_pos;
    logic              ptr_end;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/skt_dpath.sv
// skt_dpath: entry memory, fill count, scan pointers and result registers
// depends on skt_pkg; driven by skt_ctrl through cmd_t / stat_t
`default_nettype none

module skt_dpath #(
  parameter int unsigned DEPTH    = skt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire skt_pkg::cmd_t                      cmd_i,
  output skt_pkg::stat_t                          stat_o,
  input  wire logic [skt_pkg::MODE_W-1:0]         mode_i,
  input  wire logic signed [KEY_BITS-1:0]         key_i,
  input  wire logic [skt_pkg::PAYLOAD_W-1:0]      payload_i,
  output logic [skt_pkg::STATUS_W-1:0]            status_o,
  output logic signed [KEY_BITS-1:0]              removed_key_o,
  output logic [skt_pkg::PAYLOAD_W-1:0]           removed_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]              entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned WW = KEY_BITS + skt_pkg::PAYLOAD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [WW-1:0] mem [DEPTH];

  logic [skt_pkg::MODE_W-1:0]    mode_q;
  logic signed [KEY_BITS-1:0]    key_q;
  logic [skt_pkg::PAYLOAD_W-1:0] payload_q;
  logic [CW-1:0]                 fill_q, fill_d;
  logic [CW-1:0]                 ptr_q, ptr_d;
  logic [CW-1:0]                 pos_q, pos_d;
  logic [WW-1:0]                 rdata_q;
  logic [skt_pkg::STATUS_W-1:0]  status_q;
  logic signed [KEY_BITS-1:0]    rkey_q;
  logic [skt_pkg::PAYLOAD_W-1:0] rpay_q;

  logic [CW-1:0]              raddr;
  logic [CW-1:0]              waddr;
  logic [WW-1:0]              wdata;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [CW:0]                ptr_p1;

  assign rd_key = rdata_q[WW-1:skt_pkg::PAYLOAD_W];
  assign ptr_p1 = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    unique case (cmd_i.rd_sel)
      skt_pkg::RD_ZERO:   raddr = '0;
      skt_pkg::RD_LAST:   raddr = fill_q - ONE_CNT;
      skt_pkg::RD_PTR:    raddr = ptr_q;
      skt_pkg::RD_PTR_M1: raddr = ptr_q - ONE_CNT;
      skt_pkg::RD_PTR_P1: raddr = ptr_p1[CW-1:0];
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    if (cmd_i.wr_new) begin
      waddr = pos_q;
      wdata = {key_q, payload_q};
    end else begin
      waddr = ptr_q;
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      skt_pkg::PTR_HOLD:    ptr_d = ptr_q;
      skt_pkg::PTR_ZERO:    ptr_d = '0;
      skt_pkg::PTR_ONE:     ptr_d = ONE_CNT;
      skt_pkg::PTR_FILL:    ptr_d = fill_q;
      skt_pkg::PTR_FILL_M1: ptr_d = fill_q - ONE_CNT;
      skt_pkg::PTR_INC:     ptr_d = ptr_p1[CW-1:0];
      skt_pkg::PTR_DEC:     ptr_d = ptr_q - ONE_CNT;
      default:              ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.pos_op)
      skt_pkg::POS_HOLD: pos_d = pos_q;
      skt_pkg::POS_ZERO: pos_d = '0;
      skt_pkg::POS_FILL: pos_d = fill_q;
      skt_pkg::POS_PTR:  pos_d = ptr_q;
      default:           pos_d = pos_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.fill_op)
      skt_pkg::FILL_HOLD: fill_d = fill_q;
      skt_pkg::FILL_INC:  fill_d = fill_q + ONE_CNT;
      skt_pkg::FILL_DEC:  fill_d = fill_q - ONE_CNT;
      default:            fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    pos_q <= pos_d;
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      key_q     <= key_i;
      payload_q <= payload_i;
      status_q  <= skt_pkg::ST_DONE;
      rkey_q    <= '0;
      rpay_q    <= '0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.capture) begin
        rkey_q <= rd_key;
        rpay_q <= rdata_q[skt_pkg::PAYLOAD_W-1:0];
      end
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.full        = (fill_q == FULL_CNT);
    stat_o.empty       = (fill_q == '0);
    stat_o.key_ge      = (rd_key >= key_q);
    stat_o.key_le      = (rd_key <= key_q);
    stat_o.key_eq      = (rd_key == key_q);
    stat_o.ptr_eq_fill = (ptr_q == fill_q);
    stat_o.ptr_eq_pos  = (ptr_q == pos_q);
    stat_o.ptr_end     = (ptr_p1 >= {1'b0, fill_q});
  end

  assign status_o          = status_q;
  assign removed_key_o     = rkey_q;
  assign removed_payload_o = rpay_q;
  assign entry_count_o     = fill_q;

endmodule

`default_nettype wire

>>> sv/skt_ctrl.sv
// skt_ctrl: sequencer for search, shift and result of one transaction
// depends on skt_pkg; commands skt_dpath through cmd_t / stat_t
`default_nettype none

module skt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  input  wire skt_pkg::stat_t stat_i,
  output skt_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_CMP0     = 4'd2;
  localparam logic [3:0] S_CMPLAST  = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CMP = 4'd5;
  localparam logic [3:0] S_INS_CHK  = 4'd6;
  localparam logic [3:0] S_INS_RD   = 4'd7;
  localparam logic [3:0] S_INS_WR   = 4'd8;
  localparam logic [3:0] S_WR_NEW   = 4'd9;
  localparam logic [3:0] S_REM_CHK  = 4'd10;
  localparam logic [3:0] S_REM_RD   = 4'd11;
  localparam logic [3:0] S_REM_WR   = 4'd12;
  localparam logic [3:0] S_FINISH   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       is_insert;
  logic       is_remove;
  logic       is_store;

  assign is_insert = (stat_i.mode == skt_pkg::MODE_INSERT);
  assign is_remove = (stat_i.mode == skt_pkg::MODE_REMOVE);
  assign is_store  = (stat_i.mode == skt_pkg::MODE_APPEND) || is_insert;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_FINISH);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = skt_pkg::RD_ZERO;
    cmd_o.ptr_op     = skt_pkg::PTR_HOLD;
    cmd_o.pos_op     = skt_pkg::POS_HOLD;
    cmd_o.fill_op    = skt_pkg::FILL_HOLD;
    cmd_o.status     = skt_pkg::ST_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (is_store) begin
          if (stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = skt_pkg::ST_FULL;
            state_d          = S_FINISH;
          end else if (!is_insert || stat_i.empty) begin
            cmd_o.pos_op = skt_pkg::POS_FILL;
            cmd_o.ptr_op = skt_pkg::PTR_FILL;
            state_d      = S_INS_CHK;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = skt_pkg::RD_ZERO;
            state_d      = S_CMP0;
          end
        end else if (is_remove) begin
          if (stat_i.empty) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = skt_pkg::ST_NOT_FOUND;
            state_d          = S_FINISH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = skt_pkg::RD_ZERO;
            state_d      = S_CMP0;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_CMP0: begin
        if (is_insert && stat_i.key_ge) begin
          cmd_o.pos_op = skt_pkg::POS_ZERO;
          cmd_o.ptr_op = skt_pkg::PTR_FILL;
          state_d      = S_INS_CHK;
        end else if (is_remove && stat_i.key_eq) begin
          cmd_o.capture = 1'b1;
          cmd_o.ptr_op  = skt_pkg::PTR_ZERO;
          state_d       = S_REM_CHK;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_LAST;
          state_d      = S_CMPLAST;
        end
      end
      S_CMPLAST: begin
        if (is_insert && stat_i.key_le) begin
          cmd_o.pos_op = skt_pkg::POS_FILL;
          cmd_o.ptr_op = skt_pkg::PTR_FILL;
          state_d      = S_INS_CHK;
        end else if (is_remove && stat_i.key_eq) begin
          cmd_o.capture = 1'b1;
          cmd_o.ptr_op  = skt_pkg::PTR_FILL_M1;
          state_d       = S_REM_CHK;
        end else begin
          cmd_o.ptr_op = skt_pkg::PTR_ONE;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (is_insert && stat_i.ptr_eq_fill) begin
          cmd_o.pos_op = skt_pkg::POS_PTR;
          state_d      = S_INS_CHK;
        end else if (is_remove && stat_i.ptr_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = skt_pkg::ST_NOT_FOUND;
          state_d          = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_PTR;
          state_d      = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (is_insert && stat_i.key_ge) begin
          cmd_o.pos_op = skt_pkg::POS_PTR;
          cmd_o.ptr_op = skt_pkg::PTR_FILL;
          state_d      = S_INS_CHK;
        end else if (is_remove && stat_i.key_eq) begin
          cmd_o.capture = 1'b1;
          state_d       = S_REM_CHK;
        end else begin
          cmd_o.ptr_op = skt_pkg::PTR_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_INS_CHK: begin
        if (stat_i.ptr_eq_pos) begin
          state_d = S_WR_NEW;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_PTR_M1;
          state_d      = S_INS_RD;
        end
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.we     = 1'b1;
        cmd_o.ptr_op = skt_pkg::PTR_DEC;
        state_d      = S_INS_CHK;
      end
      S_WR_NEW: begin
        cmd_o.we      = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.fill_op = skt_pkg::FILL_INC;
        state_d       = S_FINISH;
      end
      S_REM_CHK: begin
        if (stat_i.ptr_end) begin
          cmd_o.fill_op = skt_pkg::FILL_DEC;
          state_d       = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skt_pkg::RD_PTR_P1;
          state_d      = S_REM_RD;
        end
      end
      S_REM_RD: begin
        state_d = S_REM_WR;
      end
      S_REM_WR: begin
        cmd_o.we     = 1'b1;
        cmd_o.ptr_op = skt_pkg::PTR_INC;
        state_d      = S_REM_CHK;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sorted_key_table.sv
// sorted_key_table: ordered key/payload table with append, sorted insert, remove
// full, unused mode or remove from empty finish without a memory access; append
// writes at the end; insert and remove compare the first and last entries, then
// scan the middle ones, then shift entries one by one to open or close the gap
// one transaction at a time: busy is high through done_o; start is taken only when idle
// reset clears the fill count and controller only; the receiver cannot stall
`default_nettype none

module sorted_key_table #(
  parameter int unsigned DEPTH    = skt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [skt_pkg::MODE_W-1:0]    mode_i,
  input  wire logic signed [KEY_BITS-1:0]    key_i,
  input  wire logic [skt_pkg::PAYLOAD_W-1:0] payload_i,
  output logic                               done_o,
  output logic [skt_pkg::STATUS_W-1:0]       status_o,
  output logic signed [KEY_BITS-1:0]         removed_key_o,
  output logic [skt_pkg::PAYLOAD_W-1:0]      removed_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]         entry_count_o
);

  skt_pkg::cmd_t  cmd;
  skt_pkg::stat_t stat;

  skt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  skt_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .key_i             (key_i),
    .payload_i         (payload_i),
    .status_o          (status_o),
    .removed_key_o     (removed_key_o),
    .removed_payload_o (removed_payload_o),
    .entry_count_o     (entry_count_o)
  );

endmodule

`default_nettype wire
